>>> hdl/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Shared constants, codes, types and helpers of the matrix multiply engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

  // matrix geometry
  localparam int MAX_DIM = 8;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;

  // datapath widths
  localparam int ELEM_W  = 16;
  localparam int MUL_W   = 2 * ELEM_W;
  localparam int PROD_W  = 35;
  localparam int ACT_W   = 2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 3'd3;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

  // item action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_START  = 2'd2
  } action_t;

  // tag that travels with one dot product term
  typedef struct packed {
    logic             first;
    logic             fin;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } term_tag_t;

  // controller to datapath commands
  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic [ADDR_W-1:0] wr_addr;
    logic [ELEM_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    term_tag_t         tag;
    logic              emit_err;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic busy;
  } dp_stat_t;

  // dimension register value as used: zero means one, above max means max
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  // clamped dimension minus one, as a loop bound
  function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    d = clamp_dim(v) - DIM_W'(1);
    return d[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/mme_in_if.sv
// ----------------------------------------------------------------------------
// mme_in_if
// Input item channel: load and start items with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mme_in_if;
  import mme_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [IDX_W-1:0]    row_index;
  logic [IDX_W-1:0]    col_index;
  logic signed [ELEM_W-1:0] elem_value;

  modport source (output valid, action, row_index, col_index, elem_value, input ready);
  modport sink   (input valid, action, row_index, col_index, elem_value, output ready);
endinterface

`default_nettype wire

>>> hdl/mme_out_if.sv
// ----------------------------------------------------------------------------
// mme_out_if
// Result item channel: product elements or a size error, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mme_out_if;
  import mme_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [PROD_W-1:0] product_value;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic                     size_error;
  logic                     last;

  modport source (output valid, product_value, out_row, out_col, size_error, last,
                  input ready);
  modport sink   (input valid, product_value, out_row, out_col, size_error, last,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/mme_datapath.sv
// ----------------------------------------------------------------------------
// mme_datapath
// Element stores, read / multiply / accumulate pipeline and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_datapath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire mme_pkg::dp_cmd_t cmd,
  output mme_pkg::dp_stat_t    stat,
  mme_out_if.source            out_ch
);
  import mme_pkg::*;

  // element stores
  logic [ELEM_W-1:0] store_a [DEPTH];
  logic [ELEM_W-1:0] store_b [DEPTH];

  // read stage
  logic                     rd_v_r;
  term_tag_t                rd_tag_r;
  logic signed [ELEM_W-1:0] a_q_r;
  logic signed [ELEM_W-1:0] b_q_r;

  // multiply stage
  logic                     mul_v_r;
  term_tag_t                mul_tag_r;
  logic signed [MUL_W-1:0]  prod_r;

  // accumulator and result register
  logic signed [PROD_W-1:0] acc_r;
  logic signed [PROD_W-1:0] acc_nxt;
  logic signed [PROD_W-1:0] prod_ext;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic signed [PROD_W-1:0] out_value_r;
  logic [IDX_W-1:0]         out_row_r;
  logic [IDX_W-1:0]         out_col_r;
  logic                     out_err_r;
  logic                     out_last_r;
  logic                     fin_hit;

  // store writes
  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      store_a[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.wr_b) begin
      store_b[cmd.wr_addr] <= cmd.wr_data;
    end
  end

  // registered store reads
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      a_q_r <= store_a[cmd.a_addr];
      b_q_r <= store_b[cmd.b_addr];
    end
    rd_tag_r  <= cmd.tag;
    mul_tag_r <= rd_tag_r;
    prod_r    <= a_q_r * b_q_r;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      rd_v_r  <= cmd.rd_en;
      mul_v_r <= rd_v_r;
    end
  end

  // accumulate, restarting on the first term of each element
  assign prod_ext = {{(PROD_W - MUL_W){prod_r[MUL_W-1]}}, prod_r};
  assign acc_nxt  = (mul_tag_r.first ? '0 : acc_r) + prod_ext;
  assign fin_hit  = mul_v_r && mul_tag_r.fin;

  always_ff @(posedge clk) begin
    if (mul_v_r) begin
      acc_r <= acc_nxt;
    end
  end

  // result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit_err || fin_hit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      out_value_r <= '0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_err_r   <= 1'b1;
      out_last_r  <= 1'b1;
    end else if (fin_hit) begin
      out_value_r <= acc_nxt;
      out_row_r   <= mul_tag_r.row;
      out_col_r   <= mul_tag_r.col;
      out_err_r   <= 1'b0;
      out_last_r  <= mul_tag_r.last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.product_value = out_value_r;
  assign out_ch.out_row       = out_row_r;
  assign out_ch.out_col       = out_col_r;
  assign out_ch.size_error    = out_err_r;
  assign out_ch.last          = out_last_r;

  // anything still in flight or waiting to be taken
  assign stat.busy = rd_v_r || mul_v_r || out_valid_r;

endmodule

`default_nettype wire

>>> hdl/mme_ctrl.sv
// ----------------------------------------------------------------------------
// mme_ctrl
// Item decode, dimension registers and the row / column / inner loop sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  mme_in_if.sink                            in_ch,
  input  wire logic                         cfg_wr_en,
  input  wire logic [mme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mme_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output mme_pkg::dp_cmd_t                  cmd,
  input  wire mme_pkg::dp_stat_t            stat
);
  import mme_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_WAIT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [DIM_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic             done_r, done_nxt;

  logic [IDX_W-1:0] ar_m1, inner_m1, bc_m1;
  logic             size_ok;
  logic             accept;
  logic             term_fin;
  logic             elem_last;

  // dimension registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= DIM_RESET;
      a_cols_r <= DIM_RESET;
      b_rows_r <= DIM_RESET;
      b_cols_r <= DIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_A_ROWS: a_rows_r <= cfg_wdata;
        REG_A_COLS: a_cols_r <= cfg_wdata;
        REG_B_ROWS: b_rows_r <= cfg_wdata;
        REG_B_COLS: b_cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // loop bounds from the clamped dimensions
  assign ar_m1    = dim_last(a_rows_r);
  assign inner_m1 = dim_last(a_cols_r);
  assign bc_m1    = dim_last(b_cols_r);
  assign size_ok  = clamp_dim(a_cols_r) == clamp_dim(b_rows_r);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign term_fin    = (j_r == inner_m1);
  assign elem_last   = (i_r == ar_m1) && (k_r == bc_m1);

  // commands to the datapath
  always_comb begin
    cmd           = '0;
    cmd.wr_addr   = {in_ch.row_index, in_ch.col_index};
    cmd.wr_data   = in_ch.elem_value;
    cmd.a_addr    = {i_r, j_r};
    cmd.b_addr    = {j_r, k_r};
    cmd.tag.first = (j_r == '0);
    cmd.tag.fin   = term_fin;
    cmd.tag.row   = i_r;
    cmd.tag.col   = k_r;
    cmd.tag.last  = elem_last;
    cmd.rd_en     = (state_r == ST_ISSUE);
    if (accept) begin
      unique case (in_ch.action)
        ACT_LOAD_A: cmd.wr_a     = 1'b1;
        ACT_LOAD_B: cmd.wr_b     = 1'b1;
        ACT_START:  cmd.emit_err = !size_ok;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    done_nxt  = done_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_ch.action == ACT_START)) begin
          i_nxt = '0;
          k_nxt = '0;
          j_nxt = '0;
          if (size_ok) begin
            done_nxt  = 1'b0;
            state_nxt = ST_ISSUE;
          end else begin
            done_nxt  = 1'b1;
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_ISSUE: begin
        if (term_fin) begin
          j_nxt     = '0;
          done_nxt  = elem_last;
          state_nxt = ST_WAIT;
          if (k_r == bc_m1) begin
            k_nxt = '0;
            i_nxt = i_r + IDX_W'(1);
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      ST_WAIT: begin
        if (!stat.busy) begin
          state_nxt = done_r ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      k_r     <= '0;
      j_r     <= '0;
      done_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/matrix_multiply_engine_unit.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine_unit
// General matrix multiply C = A * B on signed Q8.8 elements, Q19.16 results.
// ----------------------------------------------------------------------------
// Load items (action 0 for A, 1 for B) write one element each; they give no
// result. A start item (action 2) checks that the used column count of A
// equals the used row count of B; if not, one result with size_error and
// last set comes out. Otherwise every element of C is sent in row-major
// order, last set on the final one. Each element is formed one inner-dimension
// term per cycle through the single read port of each store and one
// multiplier; the sequencer then waits until the read / multiply / accumulate
// pipeline has drained and the result handshake is done. No item is accepted
// while a start runs. Dimension registers read 0 as 1 and values above 8 as
// 8; write them only while the block is idle. Reading an element that was
// never loaded gives an undefined value.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_engine_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  mme_in_if.sink                              in_ch,
  mme_out_if.source                           out_ch,
  input  wire logic                           cfg_wr_en,
  input  wire logic [mme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mme_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mme_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer and item decode
  mme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  // stores and multiply-accumulate
  mme_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .stat   (stat),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

>>> hdl/mme_checker.sv
// ----------------------------------------------------------------------------
// mme_checker
// Port-level checks of the matrix multiply engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic [mme_pkg::ACT_W-1:0]      in_action,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [mme_pkg::PROD_W-1:0]     out_product_value,
  input wire logic [mme_pkg::IDX_W-1:0]      out_row,
  input wire logic [mme_pkg::IDX_W-1:0]      out_col,
  input wire logic                           out_size_error,
  input wire logic                           out_last
);
  import mme_pkg::*;

  // a stalled item holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_product_value)
      && $stable(out_row) && $stable(out_col) && $stable(out_size_error)
      && $stable(out_last))
    else $error("result item changed while stalled");

  // error item is a lone, zeroed, last item
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_size_error |-> out_last && (out_product_value == '0)
      && (out_row == '0) && (out_col == '0))
    else $error("malformed size error item");

  // no input taken while a result is pending
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // a start item blocks the input on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_START) |=> !in_ready)
    else $error("input ready right after start");

endmodule

bind matrix_multiply_engine_unit mme_checker u_mme_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_action         (in_ch.action),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_product_value (out_ch.product_value),
  .out_row           (out_ch.out_row),
  .out_col           (out_ch.out_col),
  .out_size_error    (out_ch.size_error),
  .out_last          (out_ch.last)
);

`default_nettype wire
